>>> sv/rrrs_pkg.sv
package rrrs_pkg;

   localparam int NUM_SLOTS_DEF = 8;
   localparam int ID_WIDTH_DEF  = 16;
   localparam int READY_W       = 8;

   // request types
   localparam logic [1:0] REQ_SELECT = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_FULL       = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND  = 2'd2;
   localparam logic [1:0] ST_NONE_READY = 2'd3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] stream_id;
      logic [7:0]  ready_mask;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] granted_id;
      logic [2:0]  granted_slot;
      logic [3:0]  active_count;
   } rsp_payload_type;

   // broadcast from the controller to every cell of the ring
   typedef struct packed {
      logic run;     // pass the scan token on to the next cell
      logic remove;  // scan matches ids rather than ready bits
      logic write;   // load an id into the cell named by the write slot
      logic inject;  // place the scan token in the cell named by the start slot
   } cell_ctrl_type;

endpackage

>>> sv/rrrs_if.sv
interface rrrs_req_if;
   import rrrs_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rrrs_rsp_if;
   import rrrs_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/rrrs_cell.sv
module rrrs_cell #(
   parameter int ID_WIDTH   = rrrs_pkg::ID_WIDTH_DEF,
   parameter int SLOT_W     = 3,
   parameter int CELL_INDEX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rrrs_pkg::cell_ctrl_type ctrl,
   input  logic [SLOT_W-1:0]       wr_slot,
   input  logic [SLOT_W-1:0]       start_slot,
   input  logic [ID_WIDTH-1:0]     wr_id,
   input  logic [ID_WIDTH-1:0]     key,
   input  logic                    ready_bit,
   input  logic                    token_prev,
   output logic                    token_next,
   output logic                    hit,
   output logic [ID_WIDTH-1:0]     id
);
   import rrrs_pkg::*;

   localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(CELL_INDEX);

   logic [ID_WIDTH-1:0] id_ff, id_in;
   logic                active_ff, active_in;
   logic                token_ff, token_in;
   logic                write_me;
   logic                match;

   assign write_me = ctrl.write && (wr_slot == MY_SLOT);
   assign match    = active_ff && (ctrl.remove ? (id_ff == key) : ready_bit);
   assign hit      = token_ff && match;
   // a hit consumes the token
   assign token_next = token_ff && !hit;
   assign id         = id_ff;

   always_comb begin
      token_in  = (ctrl.run && token_prev) || (ctrl.inject && (start_slot == MY_SLOT));
      id_in     = id_ff;
      active_in = active_ff;
      if (write_me) begin
         id_in     = wr_id;
         active_in = 1'b1;
      end else if (hit && ctrl.remove) begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
      if (reset) begin
         active_ff <= 1'b0;
         token_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         token_ff  <= token_in;
      end
   end

endmodule

>>> sv/rrrs_ctrl.sv
module rrrs_ctrl #(
   parameter int NUM_SLOTS = rrrs_pkg::NUM_SLOTS_DEF,
   parameter int ID_WIDTH  = rrrs_pkg::ID_WIDTH_DEF,
   parameter int SLOT_W    = 3,
   parameter int CNT_W     = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   rrrs_req_if.sink                req_chan,
   rrrs_rsp_if.source              rsp_chan,
   output rrrs_pkg::cell_ctrl_type ctrl,
   output logic [SLOT_W-1:0]       wr_slot,
   output logic [SLOT_W-1:0]       start_slot,
   output logic [ID_WIDTH-1:0]     wr_id,
   output logic [ID_WIDTH-1:0]     key,
   output logic [rrrs_pkg::READY_W-1:0] ready_mask,
   input  logic [NUM_SLOTS-1:0]    hit_vec,
   input  logic [ID_WIDTH-1:0]     cell_id [NUM_SLOTS]
);
   import rrrs_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   localparam logic [SLOT_W-1:0] LAST_STEP = SLOT_W'(NUM_SLOTS - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(NUM_SLOTS);

   logic [1:0]           state_ff, state_in;
   logic [SLOT_W-1:0]    step_ff, step_in;
   logic [CNT_W-1:0]     slots_used_ff, slots_used_in;
   logic [CNT_W-1:0]     active_ff, active_in;
   logic [SLOT_W-1:0]    last_grant_ff, last_grant_in;
   logic [1:0]           op_ff, op_in;
   logic [ID_WIDTH-1:0]  key_ff, key_in;
   logic [READY_W-1:0]   ready_ff, ready_in;
   logic [1:0]           status_ff, status_in;
   logic [ID_WIDTH-1:0]  gid_ff, gid_in;
   logic [SLOT_W-1:0]    gslot_ff, gslot_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_ff, rsp_in;

   logic                 any_hit;
   logic [SLOT_W-1:0]    hit_slot;
   logic [ID_WIDTH-1:0]  hit_id;
   logic [CNT_W-1:0]     lg_plus;
   logic [SLOT_W-1:0]    next_start;

   // only one token is in the ring, so at most one cell hits
   always_comb begin
      hit_slot = '0;
      hit_id   = '0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
         if (hit_vec[k]) begin
            hit_slot = hit_slot | SLOT_W'(k);
            hit_id   = hit_id | cell_id[k];
         end
      end
   end
   assign any_hit = |hit_vec;

   assign lg_plus    = CNT_W'(last_grant_ff) + CNT_W'(1);
   assign next_start = (lg_plus == slots_used_ff) ? '0 : lg_plus[SLOT_W-1:0];

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;
   assign key              = key_ff;
   assign ready_mask       = ready_ff;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      slots_used_in = slots_used_ff;
      active_in     = active_ff;
      last_grant_in = last_grant_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      ready_in      = ready_ff;
      status_in     = status_ff;
      gid_in        = gid_ff;
      gslot_in      = gslot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_in        = rsp_ff;
      ctrl          = '0;
      ctrl.run      = (state_ff == S_SCAN) && (step_ff != LAST_STEP);
      ctrl.remove   = (op_ff == REQ_REMOVE);
      wr_slot       = slots_used_ff[SLOT_W-1:0];
      wr_id         = ID_WIDTH'(req_chan.payload.stream_id);
      start_slot    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in     = req_chan.payload.req_type;
               key_in    = ID_WIDTH'(req_chan.payload.stream_id);
               ready_in  = req_chan.payload.ready_mask;
               status_in = ST_OK;
               gid_in    = '0;
               gslot_in  = '0;
               step_in   = '0;
               state_in  = S_DONE;
               unique case (req_chan.payload.req_type)
                  REQ_INSERT: begin
                     if (slots_used_ff == FULL_CNT) begin
                        status_in = ST_FULL;
                     end else begin
                        ctrl.write    = 1'b1;
                        slots_used_in = slots_used_ff + CNT_W'(1);
                        active_in     = active_ff + CNT_W'(1);
                     end
                  end
                  REQ_REMOVE: begin
                     ctrl.inject = 1'b1;
                     start_slot  = '0;
                     state_in    = S_SCAN;
                  end
                  REQ_SELECT: begin
                     if (slots_used_ff == '0) begin
                        status_in = ST_NONE_READY;
                     end else begin
                        ctrl.inject = 1'b1;
                        start_slot  = next_start;
                        state_in    = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (any_hit) begin
               status_in = ST_OK;
               state_in  = S_DONE;
               if (op_ff == REQ_REMOVE) begin
                  active_in = active_ff - CNT_W'(1);
               end else begin
                  last_grant_in = hit_slot;
                  gid_in        = hit_id;
                  gslot_in      = hit_slot;
               end
            end else if (step_ff == LAST_STEP) begin
               status_in = (op_ff == REQ_REMOVE) ? ST_NOT_FOUND : ST_NONE_READY;
               state_in  = S_DONE;
            end else begin
               step_in = step_ff + SLOT_W'(1);
            end
         end
         S_DONE: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = status_ff;
               rsp_in.granted_id   = 16'(gid_ff);
               rsp_in.granted_slot = 3'(gslot_ff);
               rsp_in.active_count = 4'(active_ff);
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      ready_ff  <= ready_in;
      status_ff <= status_in;
      gid_ff    <= gid_in;
      gslot_ff  <= gslot_in;
      step_ff   <= step_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         slots_used_ff <= '0;
         active_ff     <= '0;
         last_grant_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slots_used_ff <= slots_used_in;
         active_ff     <= active_in;
         last_grant_ff <= last_grant_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one cell hit in the same cycle");

   a_active_le_used: assert property (@(posedge clock) disable iff (reset)
      active_ff <= slots_used_ff)
      else $error("active count exceeds occupied slots");

   a_used_le_depth: assert property (@(posedge clock) disable iff (reset)
      slots_used_ff <= FULL_CNT)
      else $error("occupied slot count exceeds table depth");

   a_grant_in_range: assert property (@(posedge clock) disable iff (reset)
      (slots_used_ff != '0) |-> (CNT_W'(last_grant_ff) < slots_used_ff))
      else $error("last grant points past the occupied slots");

endmodule

>>> sv/round_robin_ready_selector.sv
// Round-robin ready selector: a table of stream ids with round-robin grants.
// req_chan carries one transaction per request: insert appends an id at the
// next unused slot, remove clears the lowest active slot holding the id, and
// select grants the next active slot, after the last grant and wrapping,
// whose bit in ready_mask is set. rsp_chan returns exactly one transaction per
// request with a status, the granted id and slot, and the active count.
// The slots sit in a ring of cells; a scan token walks one cell per cycle.
// Insert, unused request types and a select on an empty table go from
// acceptance straight to the done state; remove and the other selects
// first pass through the scan state, where the token visits 1 to NUM_SLOTS
// cells. The done state loads the result into the output register that
// drives rsp_chan and returns to idle, where the next request can be taken.
// A response waits in an output register while rsp_chan stalls; the next
// request may be accepted meanwhile, and its own response holds until the
// register is free.
// Synchronous reset empties the table, clears the counts and the last grant,
// and drops any pending response; no clearing pass is needed.
module round_robin_ready_selector #(
   parameter int NUM_SLOTS = rrrs_pkg::NUM_SLOTS_DEF,
   parameter int ID_WIDTH  = rrrs_pkg::ID_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rrrs_req_if.sink   req_chan,
   rrrs_rsp_if.source rsp_chan
);
   import rrrs_pkg::*;

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

   cell_ctrl_type        ctrl;
   logic [SLOT_W-1:0]    wr_slot;
   logic [SLOT_W-1:0]    start_slot;
   logic [ID_WIDTH-1:0]  wr_id;
   logic [ID_WIDTH-1:0]  key;
   logic [READY_W-1:0]   ready_mask;
   logic [NUM_SLOTS-1:0] hit_vec;
   logic [NUM_SLOTS-1:0] token;
   logic [NUM_SLOTS-1:0] ready_bits;
   logic [ID_WIDTH-1:0]  cell_id [NUM_SLOTS];

   rrrs_ctrl #(
      .NUM_SLOTS (NUM_SLOTS),
      .ID_WIDTH  (ID_WIDTH),
      .SLOT_W    (SLOT_W),
      .CNT_W     (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .ctrl       (ctrl),
      .wr_slot    (wr_slot),
      .start_slot (start_slot),
      .wr_id      (wr_id),
      .key        (key),
      .ready_mask (ready_mask),
      .hit_vec    (hit_vec),
      .cell_id    (cell_id)
   );

   for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
      // slots beyond the ready mask are never ready
      if (k < READY_W) begin : g_rdy
         assign ready_bits[k] = ready_mask[k];
      end else begin : g_nrdy
         assign ready_bits[k] = 1'b0;
      end

      rrrs_cell #(
         .ID_WIDTH   (ID_WIDTH),
         .SLOT_W     (SLOT_W),
         .CELL_INDEX (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .wr_slot    (wr_slot),
         .start_slot (start_slot),
         .wr_id      (wr_id),
         .key        (key),
         .ready_bit  (ready_bits[k]),
         .token_prev (token[(k + NUM_SLOTS - 1) % NUM_SLOTS]),
         .token_next (token[k]),
         .hit        (hit_vec[k]),
         .id         (cell_id[k])
      );
   end

endmodule
